>>> design/kth_successor_binary_lifting_unit_defines.svh
// Assertion macros for the kth-successor binary lifting unit.
`ifndef KTH_SUCCESSOR_BINARY_LIFTING_UNIT_DEFINES_SVH
`define KTH_SUCCESSOR_BINARY_LIFTING_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KSLU_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KSLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/kslu_pkg.sv
// Shared types and constants of the kth-successor binary lifting unit.
`default_nettype none

package kslu_pkg;

    localparam int NODE_W     = 11;
    localparam int STEP_W     = 30;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // tuser kind codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register index (paddr[2])
    localparam logic REG_IDX_NODE_COUNT = 1'b0;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RB_A   = 7'b0000010,
        S_RB_B   = 7'b0000100,
        S_RB_C   = 7'b0001000,
        S_Q_STEP = 7'b0010000,
        S_Q_WAIT = 7'b0100000,
        S_Q_DONE = 7'b1000000
    } t_state;

    // Node 0 and nodes above the active count form the sink.
    function automatic logic node_ok(input logic [NODE_W-1:0] node,
                                     input logic [NODE_W-1:0] n);
        return (node != '0) && (node <= n);
    endfunction

endpackage

`default_nettype wire

>>> design/kslu_jump_mem.sv
// Jump table memory: one write port, one registered read port.
`default_nettype none

module kslu_jump_mem #(
    parameter int DEPTH = 30720,
    parameter int AW    = 15,
    parameter int DW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/kth_successor_binary_lifting_unit.sv
// Top level: kth successor in a functional graph by binary lifting.
// Loads write a node's successor into level 0 of the jump memory. A query
// walks the step count from its low bit up to its highest set bit, with one
// jump memory read per set bit, and then hands over the result.
// The first query after a load or a node_count write first rebuilds levels
// 1..LEVELS-1: each entry needs up to two dependent reads of the single
// read port.
// Entries are undefined until loaded; there is no clearing pass after reset.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

`include "kth_successor_binary_lifting_unit_defines.svh"

module kth_successor_binary_lifting_unit
    import kslu_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 30
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // stream in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [10:0] node_index, [21:11] successor, [51:22] step_count, [55:52] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  wire logic                  s_tuser,
    // stream out
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [10:0] dest_node, [15:11] zero
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int NAW   = $clog2(MAX_NODES);
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW    = LW + NAW;
    localparam int DEPTH = LEVELS * (2 ** NAW);
    localparam int XW    = (NAW > NODE_W) ? NAW : NODE_W;
    localparam int MAXN  = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
    localparam logic [NODE_W-1:0] MAXN_V  = NODE_W'(MAXN);
    localparam logic [LW-1:0]     LVL_TOP = LW'(LEVELS - 1);
    localparam logic [STEP_W-1:0] STEP_MASK = (LEVELS >= STEP_W) ? {STEP_W{1'b1}} :
        STEP_W'((64'd1 << LEVELS) - 64'd1);

    function automatic logic [NAW-1:0] f_idx(input logic [NODE_W-1:0] node);
        logic [XW-1:0] t;
        t = XW'(node) - XW'(1);
        return t[NAW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic                r_stale, n_stale;
    logic [NODE_W-1:0]   r_node_count, n_node_count;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [NODE_W-1:0]   r_j, n_j;
    logic                r_out_valid, n_out_valid;
    logic [NODE_W-1:0]   r_dest, n_dest;

    logic                mem_we, mem_re, rb_adv, cfg_wr;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [NODE_W-1:0]   mem_wdata, mem_rdata, act_n;
    logic [LW-1:0]       lvl_prev;
    logic [NODE_W-1:0]   in_node, in_succ;
    logic [STEP_W-1:0]   in_steps;

    assign in_node  = s_tdata[NODE_W-1:0];
    assign in_succ  = s_tdata[2*NODE_W-1:NODE_W];
    assign in_steps = s_tdata[2*NODE_W+STEP_W-1:2*NODE_W];

    assign act_n    = (r_node_count > MAXN_V) ? MAXN_V : r_node_count;
    assign lvl_prev = r_lvl - LW'(1);
    assign cfg_wr   = psel & penable & pwrite & pready;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(M_TDATA_W-NODE_W){1'b0}}, r_dest};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_IDX_NODE_COUNT) ? CFG_DATA_W'(r_node_count) : '0;

    kslu_jump_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (NODE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_stale      = r_stale;
        n_node_count = r_node_count;
        n_node       = r_node;
        n_steps      = r_steps;
        n_lvl        = r_lvl;
        n_j          = r_j;
        n_out_valid  = r_out_valid;
        n_dest       = r_dest;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        rb_adv       = 1'b0;

        if (cfg_wr && (paddr[2] == REG_IDX_NODE_COUNT)) begin
            n_node_count = pwdata[NODE_W-1:0];
            n_stale      = 1'b1;
        end

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_LOAD) begin
                        if (node_ok(in_node, act_n)) begin
                            mem_we    = 1'b1;
                            mem_waddr = {LW'(0), f_idx(in_node)};
                            mem_wdata = in_succ;
                            n_stale   = 1'b1;
                        end
                    end else begin
                        n_node  = in_node;
                        n_steps = in_steps & STEP_MASK;
                        n_lvl   = '0;
                        if (r_stale && (LEVELS > 1) && (act_n != '0)) begin
                            n_state = S_RB_A;
                            n_lvl   = LW'(1);
                            n_j     = NODE_W'(1);
                        end else begin
                            n_stale = 1'b0;
                            n_state = S_Q_STEP;
                        end
                    end
                end
            end
            S_RB_A: begin
                mem_re    = 1'b1;
                mem_raddr = {lvl_prev, f_idx(r_j)};
                n_state   = S_RB_B;
            end
            S_RB_B: begin
                // mid node is on the read port now
                if (node_ok(mem_rdata, act_n)) begin
                    mem_re    = 1'b1;
                    mem_raddr = {lvl_prev, f_idx(mem_rdata)};
                    n_state   = S_RB_C;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_lvl, f_idx(r_j)};
                    mem_wdata = '0;
                    rb_adv    = 1'b1;
                end
            end
            S_RB_C: begin
                mem_we    = 1'b1;
                mem_waddr = {r_lvl, f_idx(r_j)};
                mem_wdata = mem_rdata;
                rb_adv    = 1'b1;
            end
            S_Q_STEP: begin
                if (r_steps == '0) begin
                    n_state = S_Q_DONE;
                end else begin
                    if (r_steps[0]) begin
                        if (node_ok(r_node, act_n)) begin
                            mem_re    = 1'b1;
                            mem_raddr = {r_lvl, f_idx(r_node)};
                            n_state   = S_Q_WAIT;
                        end else begin
                            n_node = '0;
                        end
                    end
                    n_steps = r_steps >> 1;
                    n_lvl   = r_lvl + LW'(1);
                end
            end
            S_Q_WAIT: begin
                n_node  = mem_rdata;
                n_state = S_Q_STEP;
            end
            S_Q_DONE: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid = 1'b1;
                    n_dest      = r_node;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (rb_adv) begin
            if (r_j == act_n) begin
                if (r_lvl == LVL_TOP) begin
                    n_stale = 1'b0;
                    n_lvl   = '0;
                    n_state = S_Q_STEP;
                end else begin
                    n_lvl   = r_lvl + LW'(1);
                    n_j     = NODE_W'(1);
                    n_state = S_RB_A;
                end
            end else begin
                n_j     = r_j + NODE_W'(1);
                n_state = S_RB_A;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stale      <= 1'b1;
            r_node_count <= NODE_W'(1024);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_stale      <= n_stale;
            r_node_count <= n_node_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_steps <= n_steps;
        r_lvl   <= n_lvl;
        r_j     <= n_j;
        r_dest  <= n_dest;
    end

    `KSLU_ASSERT_HOLD(a_rb_ctx, (r_state == S_RB_A || r_state == S_RB_B || r_state == S_RB_C), (r_stale && r_j != '0 && r_lvl != '0), "rebuild running with bad context")
    `KSLU_ASSERT_HOLD(a_walk_no_wr, (r_state == S_Q_STEP || r_state == S_Q_WAIT), !mem_we, "jump memory written during a walk")
    `KSLU_ASSERT_HOLD(a_walk_lvl, (r_state == S_Q_STEP && r_steps != '0), (r_lvl <= LVL_TOP), "walk level past top level")
    `KSLU_ASSERT_HOLD(a_out_src, $rose(m_tvalid), ($past(r_state) == S_Q_DONE), "result raised outside handover")
    `KSLU_ASSERT_NEXT(a_rb_next, (r_state == S_RB_C), (r_state == S_RB_A || r_state == S_Q_STEP), "rebuild write not followed by next entry")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench of the kth-successor binary lifting unit.
`timescale 1ns / 100ps

module testbench import kslu_pkg::*; ();

    localparam int          NODE_SLOTS    = 1024;
    localparam int          LARGE_NODES   = 512;
    localparam int          LIFT_LEVELS   = 30;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          PHASE_ITEMS   = 40;
    localparam int          RAND_PHASES   = 8;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam logic [CFG_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_IDX_NODE_COUNT, 2'b00};

    // Predicts the node reached by each query and holds the pending answers.
    class dest_scoreboard;
        bit [NODE_W-1:0] lift [LIFT_LEVELS][NODE_SLOTS];
        bit [NODE_W-1:0] pending_dest [$];
        int unsigned     active_nodes;
        bit              levels_stale;
        int unsigned     failures;

        function new();
            active_nodes = NODE_SLOTS;
            levels_stale = 1'b1;
            failures     = 0;
        endfunction

        function void report(string what, int unsigned expv, int unsigned gotv);
            failures++;
            if (failures <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, expv, gotv);
        endfunction

        function void set_node_count(bit [NODE_W-1:0] value);
            active_nodes = (value > NODE_SLOTS) ? NODE_SLOTS : value;
            levels_stale = 1'b1;
        endfunction

        // Node 0 and nodes past the active count fall into the sink.
        function bit [NODE_W-1:0] hop(int level, bit [NODE_W-1:0] node);
            if (node == 0 || node > active_nodes)
                return '0;
            return lift[level][node - 1];
        endfunction

        function void relift_levels();
            bit [NODE_W-1:0] mid;
            for (int lv = 1; lv < LIFT_LEVELS; lv++) begin
                for (int j = 1; j <= active_nodes; j++) begin
                    mid = hop(lv - 1, NODE_W'(j));
                    lift[lv][j - 1] = hop(lv - 1, mid);
                end
            end
            levels_stale = 1'b0;
        endfunction

        function void note_item(logic req, bit [NODE_W-1:0] node, bit [NODE_W-1:0] succ,
                                bit [STEP_W-1:0] steps);
            bit [NODE_W-1:0] cur;
            if (req == REQ_LOAD) begin
                if (node != 0 && node <= active_nodes) begin
                    lift[0][node - 1] = succ;
                    levels_stale = 1'b1;
                end
                return;
            end
            if (levels_stale)
                relift_levels();
            cur = node;
            for (int b = 0; b < LIFT_LEVELS; b++)
                if (steps[b])
                    cur = hop(b, cur);
            pending_dest = {pending_dest, cur};
        endfunction

        function void check_dest(bit [NODE_W-1:0] got);
            bit [NODE_W-1:0] want;
            if (pending_dest.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result dest_node=%0d", $realtime, got);
                return;
            end
            want = pending_dest.pop_front();
            if (want != got)
                report("dest_node", want, got);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    dest_scoreboard sb;
    bit             no_idle;
    int unsigned    cycles;

    kth_successor_binary_lifting_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[kth_successor_binary_lifting_unit] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_dest(m_tdata[NODE_W-1:0]);
    end

    // Result-side back-pressure; every gap is drawn anew per transaction.
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            @(negedge i_clk);
        end
    end

    // Entered and left at a falling edge; tvalid stays high into the next item only when no gap is drawn.
    task automatic send_item(input logic req, input bit [NODE_W-1:0] node,
                             input bit [NODE_W-1:0] succ, input bit [STEP_W-1:0] steps);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, steps, succ, node};
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        sb.note_item(req, node, succ, steps);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_dest.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_node_count(input bit [NODE_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_node_count(value);
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != CFG_DATA_W'(value))
            sb.report("node_count readback", value, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic bit [STEP_W-1:0] rand_steps(int unsigned n);
        bit [STEP_W-1:0] full;
        full = STEP_W'($urandom());
        case ($urandom_range(0, 4))
            0: return '0;
            1: return STEP_W'($urandom_range(0, 4 * n + 4));
            2: return full;
            3: return (STEP_W'(1) << $urandom_range(0, STEP_W - 1)) - STEP_W'($urandom_range(0, 1));
            default: return full >> $urandom_range(0, STEP_W - 1);
        endcase
    endfunction

    function automatic bit [NODE_W-1:0] rand_node(int unsigned n, int unsigned wild_pct);
        if ($urandom_range(0, 99) < wild_pct)
            return NODE_W'($urandom_range(0, 2047));
        return NODE_W'($urandom_range(1, n));
    endfunction

    initial begin
        int unsigned     n;
        int unsigned     done;
        int unsigned     loads;
        int unsigned     queries;
        bit [NODE_W-1:0] node;
        sb       = new();
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_LOAD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cycles   = 0;
        no_idle  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a 4-node cycle, ignored loads, sink entry and step extremes.
        set_node_count(4);
        send_item(REQ_LOAD, 1, 2, 0);
        send_item(REQ_LOAD, 2, 3, '1);
        send_item(REQ_LOAD, 3, 4, 0);
        send_item(REQ_LOAD, 4, 1, 0);
        send_item(REQ_LOAD, 0, 3, 0);
        send_item(REQ_LOAD, 5, 1, 0);
        send_item(REQ_LOAD, 2047, 2047, '1);
        send_item(REQ_QUERY, 1, 0, 0);
        send_item(REQ_QUERY, 2047, 2047, 0);
        send_item(REQ_QUERY, 0, 0, 0);
        send_item(REQ_QUERY, 1, 0, 1);
        send_item(REQ_QUERY, 2, 0, 5);
        send_item(REQ_QUERY, 3, 0, '1);
        send_item(REQ_QUERY, 3, 0, STEP_W'(1) << (STEP_W - 1));
        send_item(REQ_QUERY, 0, 0, 3);
        send_item(REQ_QUERY, 5, 0, 1);
        send_item(REQ_LOAD, 4, 2047, 0);
        send_item(REQ_QUERY, 1, 0, 3);
        send_item(REQ_QUERY, 1, 0, 4);
        send_item(REQ_QUERY, 4, 0, 0);
        send_item(REQ_LOAD, 2, 0, 0);
        send_item(REQ_QUERY, 1, 0, 1);
        send_item(REQ_QUERY, 1, 0, 2);
        send_item(REQ_LOAD, 4, 1, 0);
        send_item(REQ_QUERY, 4, 0, 7);
        wait_idle();

        // Large table: every node loaded, then one large rebuild.
        no_idle = 1'b1;
        set_node_count(NODE_W'(LARGE_NODES));
        for (int j = 1; j <= LARGE_NODES; j++)
            send_item(REQ_LOAD, NODE_W'(j), rand_node(LARGE_NODES, 10), 0);
        no_idle = 1'b0;
        send_item(REQ_QUERY, NODE_W'(LARGE_NODES), 0, '1);
        for (int q = 0; q < 30; q++)
            send_item(REQ_QUERY, rand_node(LARGE_NODES, 10), 0, rand_steps(LARGE_NODES));
        wait_idle();

        // Random phases on small graphs: load bursts followed by query bursts.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                n = 1;
            else if (ph == RAND_PHASES - 1)
                n = $urandom_range(25, 64);
            else
                n = $urandom_range(2, 24);
            no_idle = (ph == 3);
            set_node_count(NODE_W'(n));
            done = 0;
            while (done < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 12) begin
                    // noise: anything the fields allow
                    node = NODE_W'($urandom_range(0, 2047));
                    send_item(logic'($urandom_range(0, 1)), node,
                              NODE_W'($urandom_range(0, 2047)), STEP_W'($urandom()));
                    if (node != 0 && node <= n)
                        done++;
                end else begin
                    loads   = $urandom_range(0, 4);
                    queries = $urandom_range(1, 5);
                    repeat (loads) begin
                        node = rand_node(n, 8);
                        send_item(REQ_LOAD, node, rand_node(n, 15), STEP_W'($urandom()));
                        if (node != 0 && node <= n)
                            done++;
                    end
                    repeat (queries) begin
                        send_item(REQ_QUERY, rand_node(n, 10), NODE_W'($urandom_range(0, 2047)),
                                  rand_steps(n));
                        done++;
                    end
                end
            end
            wait_idle();
        end

        s_tvalid <= 1'b0;
        while (sb.pending_dest.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending_dest.size() == 0)
            $display("[kth_successor_binary_lifting_unit] OK");
        else
            $display("[kth_successor_binary_lifting_unit] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/kslu_pkg.sv
design/kslu_jump_mem.sv
design/kth_successor_binary_lifting_unit.sv
dv/testbench.sv
